FILE: src/stl_pkg.sv
// Shared types and constants for the source text lexer.
// Used by stl_front, stl_queue, stl_back and source_text_lexer; no dependencies.
`default_nettype none

package stl_pkg;

  // Field widths of the token words
  localparam int KIND_W = 5;
  localparam int POS_W  = 16;
  localparam int LEN_W  = 8;

  // Batch queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Character codes
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // Keyword spellings, last byte in the low bits
  localparam logic [23:0] KW_LET  = 24'h6C6574;
  localparam logic [15:0] KW_IF   = 16'h6966;
  localparam logic [31:0] KW_ELSE = 32'h656C7365;
  localparam logic [23:0] KW_FOR  = 24'h666F72;

  typedef enum logic [KIND_W-1:0] {
    K_LET, K_IF, K_ELSE, K_FOR, K_IDENT, K_INT,
    K_LE, K_GE, K_NE, K_EQEQ, K_LT, K_GT, K_ASSIGN,
    K_PLUS, K_MINUS, K_STAR, K_SLASH, K_PERCENT, K_AMP, K_PIPE, K_CARET, K_TILDE,
    K_LPAREN, K_RPAREN, K_LBRACE, K_RBRACE, K_SEMI, K_INVALID
  } kind_t;

  // Pending run held by the front
  typedef enum logic [1:0] {
    RUN_NONE,
    RUN_IDENT,
    RUN_INT,
    RUN_OP
  } run_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    kind_t            token_kind;
    logic [POS_W-1:0] start_row;
    logic [POS_W-1:0] start_column;
    logic [LEN_W-1:0] token_length;
    logic             last_of_batch;
  } out_word_t;

  typedef struct packed {
    kind_t            token_kind;
    logic [POS_W-1:0] start_row;
    logic [POS_W-1:0] start_column;
    logic [LEN_W-1:0] token_length;
  } tok_t;

  // Tokens caused by one input byte; tok1 is meaningful only when two is set
  typedef struct packed {
    tok_t tok0;
    tok_t tok1;
    logic two;
  } batch_t;

  // Single-character operators and punctuation
  function automatic kind_t single_kind(logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_STAR;
      CH_SLASH:  k = K_SLASH;
      CH_PCT:    k = K_PERCENT;
      CH_AMP:    k = K_AMP;
      CH_PIPE:   k = K_PIPE;
      CH_CARET:  k = K_CARET;
      CH_TILDE:  k = K_TILDE;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_SEMI:   k = K_SEMI;
      default:   k = K_INVALID;
    endcase
    return k;
  endfunction

  // Comparison lead character not followed by '='
  function automatic kind_t lone_kind(logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_LT:   k = K_LT;
      CH_GT:   k = K_GT;
      CH_EQ:   k = K_ASSIGN;
      default: k = K_INVALID;
    endcase
    return k;
  endfunction

  // Comparison lead character followed by '='
  function automatic kind_t pair_kind(logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_LT:   k = K_LE;
      CH_GT:   k = K_GE;
      CH_BANG: k = K_NE;
      default: k = K_EQEQ;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: src/stl_front.sv
// Front end of the lexer: classifies each byte, tracks position and the pending run.
// Produces the batch of tokens caused by each accepted byte. Depends on stl_pkg.
`default_nettype none

module stl_front import stl_pkg::*; #(
  parameter int POSITION_BITS = 16,
  parameter int LENGTH_BITS   = 8
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_ready,
  input  wire in_word_t in_data,
  output logic          batch_valid,
  output batch_t        batch
);

  localparam int PB = POSITION_BITS;
  localparam int LB = LENGTH_BITS;
  localparam logic [PB-1:0] POS_MAX = '1;
  localparam logic [LB-1:0] LEN_MAX = '1;

  logic [PB-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [PB-1:0] srow_r, srow_nxt, scol_r, scol_nxt;
  logic [LB-1:0] len_r, len_nxt;
  logic [31:0]   win_r, win_nxt;   // last four run bytes; low byte doubles as pending operator
  run_t          run_r, run_nxt;

  // Run state after the byte, before the end-of-text flush
  run_t          run_mid;
  logic [PB-1:0] srow_mid, scol_mid;
  logic [LB-1:0] len_mid;
  logic [31:0]   win_mid;

  logic [7:0] c;
  logic       last, acc;
  logic       is_alpha, is_digit, is_space, is_cmp, ident_ok;
  logic       ext_ok, eq_pair, used;

  tok_t a_tok, b_tok, c_tok, x_tok;
  logic a_v, b_v, c_v, x_v;

  function automatic tok_t mk_tok(kind_t k, logic [PB-1:0] r, logic [PB-1:0] col,
                                  logic [LB-1:0] len);
    tok_t t;
    t.token_kind   = k;
    t.start_row    = POS_W'(r);
    t.start_column = POS_W'(col);
    t.token_length = LEN_W'(len);
    return t;
  endfunction

  // Keywords need the exact length, so a saturated run never matches
  function automatic kind_t ident_kind(logic [LB-1:0] len, logic [31:0] w);
    kind_t k;
    if (len == LB'(3) && w[23:0] == KW_LET) k = K_LET;
    else if (len == LB'(2) && w[15:0] == KW_IF) k = K_IF;
    else if (len == LB'(4) && w == KW_ELSE) k = K_ELSE;
    else if (len == LB'(3) && w[23:0] == KW_FOR) k = K_FOR;
    else k = K_IDENT;
    return k;
  endfunction

  // Byte classes
  assign c        = in_data.char_code;
  assign last     = in_data.end_of_text;
  assign acc      = in_valid && in_ready;
  assign is_alpha = (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
  assign is_digit = c >= CH_0 && c <= CH_9;
  assign is_space = c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  assign is_cmp   = c == CH_LT || c == CH_GT || c == CH_EQ || c == CH_BANG;
  assign ident_ok = is_alpha || is_digit || c == CH_UNDER;

  // Does the byte continue the pending run
  assign ext_ok  = (run_r == RUN_IDENT && ident_ok) || (run_r == RUN_INT && is_digit);
  assign eq_pair = run_r == RUN_OP && c == CH_EQ;
  assign used    = ext_ok || eq_pair;

  // Next state
  always_comb begin
    run_mid  = run_r;
    srow_mid = srow_r;
    scol_mid = scol_r;
    len_mid  = len_r;
    win_mid  = win_r;
    if (ext_ok) begin
      if (len_r != LEN_MAX) len_mid = len_r + 1'b1;
      win_mid = {win_r[23:0], c};
    end else begin
      run_mid = RUN_NONE;
    end
    if (!used && !is_space && (is_alpha || is_digit || is_cmp)) begin
      run_mid  = is_alpha ? RUN_IDENT : (is_digit ? RUN_INT : RUN_OP);
      srow_mid = row_r;
      scol_mid = col_r;
      len_mid  = LB'(1);
      win_mid  = {24'h0, c};
    end

    // Position: newline moves to the next row, anything else one column on
    row_nxt = row_r;
    col_nxt = col_r;
    if (c == CH_LF) begin
      if (row_r != POS_MAX) row_nxt = row_r + 1'b1;
      col_nxt = PB'(1);
    end else if (col_r != POS_MAX) begin
      col_nxt = col_r + 1'b1;
    end

    run_nxt  = run_mid;
    srow_nxt = srow_mid;
    scol_nxt = scol_mid;
    len_nxt  = len_mid;
    win_nxt  = win_mid;
    // End of text: back to the start of a new text
    if (last) begin
      run_nxt  = RUN_NONE;
      row_nxt  = PB'(1);
      col_nxt  = PB'(1);
      srow_nxt = '0;
      scol_nxt = '0;
      len_nxt  = '0;
      win_nxt  = '0;
    end
  end

  // Tokens: a closes the old run, b is a single-character token,
  // c is the run flushed at end of text
  always_comb begin
    a_v   = 1'b0;
    a_tok = mk_tok(K_INVALID, srow_r, scol_r, len_r);
    unique case (run_r)
      RUN_OP: begin
        a_v = 1'b1;
        if (eq_pair) a_tok = mk_tok(pair_kind(win_r[7:0]), srow_r, scol_r, LB'(2));
        else         a_tok = mk_tok(lone_kind(win_r[7:0]), srow_r, scol_r, LB'(1));
      end
      RUN_IDENT: begin
        a_v   = !ext_ok;
        a_tok = mk_tok(ident_kind(len_r, win_r), srow_r, scol_r, len_r);
      end
      RUN_INT: begin
        a_v   = !ext_ok;
        a_tok = mk_tok(K_INT, srow_r, scol_r, len_r);
      end
      default: a_v = 1'b0;
    endcase

    b_v   = !used && !is_space && !is_alpha && !is_digit && !is_cmp;
    b_tok = mk_tok(single_kind(c), row_r, col_r, LB'(1));

    c_v = last && run_mid != RUN_NONE;
    unique case (run_mid)
      RUN_IDENT: c_tok = mk_tok(ident_kind(len_mid, win_mid), srow_mid, scol_mid, len_mid);
      RUN_INT:   c_tok = mk_tok(K_INT, srow_mid, scol_mid, len_mid);
      RUN_OP:    c_tok = mk_tok(lone_kind(win_mid[7:0]), srow_mid, scol_mid, LB'(1));
      default:   c_tok = mk_tok(K_INVALID, srow_mid, scol_mid, len_mid);
    endcase

    x_v   = b_v || c_v;
    x_tok = b_v ? b_tok : c_tok;

    batch.tok0  = a_v ? a_tok : x_tok;
    batch.tok1  = x_tok;
    batch.two   = a_v && x_v;
    batch_valid = acc && (a_v || x_v);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= PB'(1);
      col_r <= PB'(1);
      run_r <= RUN_NONE;
    end else if (acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      run_r <= run_nxt;
    end
  end

  // Run payload
  always_ff @(posedge clk) begin
    if (acc) begin
      srow_r <= srow_nxt;
      scol_r <= scol_nxt;
      len_r  <= len_nxt;
      win_r  <= win_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_eot_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc && last |=> row_r == PB'(1) && col_r == PB'(1) && run_r == RUN_NONE)
    else $error("front did not return to start of text after end_of_text");
`endif

endmodule

`default_nettype wire

FILE: src/stl_queue.sv
// Short batch queue between the lexer front and back ends.
// Register-based FIFO of token batches. Depends on stl_pkg.
`default_nettype none

module stl_queue import stl_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire batch_t push_batch,
  output logic        space,
  input  wire logic   pop,
  output logic        head_valid,
  output batch_t      head_batch
);

  batch_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;

  assign space      = cnt_r != QCNT_W'(QDEPTH);
  assign head_valid = cnt_r != '0;
  assign head_batch = mem_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_batch;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r != QCNT_W'(QDEPTH))
    else $error("batch queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("batch queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("batch queue count did not advance on push");
`endif

endmodule

`default_nettype wire

FILE: src/stl_back.sv
// Lexer back end: takes queue batches, hands out one token word a cycle while out_ready is
// high. Holds the output register; marks the final word of each batch. Depends on stl_pkg.
`default_nettype none

module stl_back import stl_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_valid,
  input  wire batch_t q_batch,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output out_word_t   out_data
);

  batch_t batch_r;
  logic   vld_r;
  logic   sel_r;   // 0 first token, 1 second token
  logic   last_word, take;
  tok_t   cur;

  assign last_word = !batch_r.two || sel_r;
  assign take      = !vld_r || (out_ready && last_word);
  assign q_pop     = q_valid && take;

  // Output word
  assign cur                    = sel_r ? batch_r.tok1 : batch_r.tok0;
  assign out_valid              = vld_r;
  assign out_data.token_kind    = cur.token_kind;
  assign out_data.start_row     = cur.start_row;
  assign out_data.start_column  = cur.start_column;
  assign out_data.token_length  = cur.token_length;
  assign out_data.last_of_batch = last_word;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sel_r <= 1'b0;
    end else if (vld_r && out_ready && !last_word) begin
      sel_r <= 1'b1;
    end else if (take) begin
      vld_r <= q_valid;
      sel_r <= 1'b0;
    end
  end

  // Batch payload
  always_ff @(posedge clk) begin
    if (q_pop) batch_r <= q_batch;
  end

`ifndef ASSERT_OFF
  a_second_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_word |=> out_valid && sel_r)
    else $error("second token of a batch was dropped");
`endif

endmodule

`default_nettype wire

FILE: src/source_text_lexer.sv
// A token word passes through the batch queue and then the output register before it
// appears on out_valid, following the cycle that accepts the byte closing it.
// Throughput: one byte accepted per cycle, one token word delivered per cycle while
// out_ready is high; a byte closing two tokens gives two output words, absorbed by a 4-batch
// queue. in_ready drops only while that queue is full.
// Reset: synchronous active-low; row and column return to 1, no run pending, queue empty.
// Top level: stl_front -> stl_queue -> stl_back. Depends on stl_pkg.
`default_nettype none

module source_text_lexer import stl_pkg::*; #(
  parameter int POSITION_BITS = 16,
  parameter int LENGTH_BITS   = 8
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_word_t     out_data
);

  logic   f_valid, q_space, q_valid, q_pop;
  batch_t f_batch, q_batch;

  assign in_ready = q_space;

  // Byte classification and run tracking
  stl_front #(
    .POSITION_BITS(POSITION_BITS),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .batch_valid(f_valid),
    .batch      (f_batch)
  );

  // Decoupling queue
  stl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_batch(f_batch),
    .space     (q_space),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_batch(q_batch)
  );

  // Token word output
  stl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_batch  (q_batch),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
